@@ hdl/bitmap_set_clear_find_top_defines.svh @@
// Assertion macros shared by the bitmap block checker.
`ifndef BITMAP_SET_CLEAR_FIND_TOP_DEFINES_SVH
`define BITMAP_SET_CLEAR_FIND_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BSCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BSCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bscf_pkg.sv @@
// Shared types and constants of the bitmap set/clear/find block.
`default_nettype none

package bscf_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;   // bit offset inside a word
    localparam int IDX_W     = 10;
    localparam int CMD_W     = 3;
    localparam int LEN_W     = 11;
    localparam int STEPS     = 6;   // halving steps of the bit search

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_GET        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_SET   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_SCAN,
        ST_BITS,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic                 find_msb;  // 1: highest set bit, 0: lowest set bit
        logic [WORD_BITS-1:0] value;
    } search_req_t;

    typedef struct packed {
        logic             done;
        logic [BIT_W-1:0] index;
    } search_resp_t;

endpackage

`default_nettype wire

@@ hdl/bscf_bit_search.sv @@
// Iterative highest/lowest set bit search over one 64-bit word, one halving step a cycle.
`default_nettype none

module bscf_bit_search (
    input  wire                   clk,
    input  wire                   rst_n,
    input  bscf_pkg::search_req_t  req,
    output bscf_pkg::search_resp_t resp
);

    logic [bscf_pkg::WORD_BITS-1:0] val_reg, val_next;
    logic [bscf_pkg::BIT_W-1:0]     idx_reg, idx_next;
    logic [2:0]                     step_reg, step_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           msb_reg, msb_next;

    logic [bscf_pkg::BIT_W-1:0]     half;
    logic [bscf_pkg::WORD_BITS-1:0] shifted;
    logic [bscf_pkg::WORD_BITS-1:0] low_mask;
    logic                           take;

    // Window halves every step: 32, 16, 8, 4, 2, 1.
    assign half     = 6'd32 >> step_reg;
    assign shifted  = val_reg >> half;
    assign low_mask = (64'd1 << half) - 64'd1;
    assign take     = msb_reg ? (shifted != '0) : ((val_reg & low_mask) == '0);

    always_comb
    begin
        val_next  = val_reg;
        idx_next  = idx_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        msb_next  = msb_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            val_next  = req.value;
            idx_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
            msb_next  = req.find_msb;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                val_next = shifted;
                idx_next = idx_reg | half;
            end
            step_next = step_reg + 3'd1;
            if (step_reg == 3'(bscf_pkg::STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        idx_reg <= idx_next;
        msb_reg <= msb_next;
    end

    assign resp.done  = done_reg;
    assign resp.index = idx_reg;

endmodule

`default_nettype wire

@@ hdl/bitmap_set_clear_find_top.sv @@
// Top level of the bitmap store with get, set, clear and find-first searches.
//
// Usage notes:
//  - Input channel s_*: one command per transaction. s_tuser carries cmd, s_tdata
//    carries the bit position. Output channel m_*: exactly one result per command.
//  - One command at a time: s_tready drops after a transaction and rises again
//    once the result has moved into the output register.
//  - Get, set and clear: one read-modify-write of a memory word, through the
//    states READ, MODIFY and EMIT from acceptance to m_tvalid.
//  - Searches scan the words one per cycle through the single memory read port,
//    then resolve the bit inside the hit word in 6 steps of the bit search unit.
//  - s_tready returns in the cycle m_tvalid rises.
//  - A receiver stall holds the result in the output register; the next command
//    is still taken and waits in its last state until the register frees up.
//  - Reset: bits_in_use returns to 1024 and a clearing pass writes zeros to all
//    NUM_WORDS words, one per cycle; s_tready stays low during that pass.
//  - cfg_we writes bits_in_use; write it only while no command is in flight.
`default_nettype none

module bitmap_set_clear_find_top #(
    parameter int MAP_BITS = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    // input command channel
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [9:0] bit position, rest zero
    input  wire  [2:0]  s_tuser,   // [2:0] cmd
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [0] bit_value, [1] found, [11:2] position
    // configuration
    input  wire         cfg_we,
    input  wire  [10:0] cfg_wdata  // bits_in_use
);

    localparam int NUM_WORDS = (MAP_BITS + bscf_pkg::WORD_BITS - 1) / bscf_pkg::WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CW        = $clog2(NUM_WORDS + 1);
    localparam int WB        = bscf_pkg::WORD_BITS;

    bscf_pkg::state_t state_reg, state_next;

    logic [bscf_pkg::LEN_W-1:0] bits_in_use_reg;
    logic [bscf_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [bscf_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]              cnt_reg, cnt_next;       // init sweep / next word to read
    logic [CW-1:0]              chk_word_reg, chk_word_next;
    logic                       chk_valid_reg, chk_valid_next;

    logic                       res_bit_reg, res_bit_next;
    logic                       res_found_reg, res_found_next;
    logic [bscf_pkg::IDX_W-1:0] res_pos_reg, res_pos_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [15:0]                m_tdata_reg, m_tdata_next;

    // word memory
    logic [WB-1:0] mem [NUM_WORDS];
    logic [WB-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WB-1:0] wr_data;

    bscf_pkg::search_req_t  srch_req;
    bscf_pkg::search_resp_t srch_resp;

    logic                       accept;
    logic                       out_free;
    logic [bscf_pkg::LEN_W-1:0] len;
    logic [6:0]                 limit;
    logic                       in_range;
    logic                       is_find_set;
    logic                       in_map;
    logic [AW-1:0]              item_addr;
    logic [bscf_pkg::BIT_W-1:0] item_bit;
    logic [31:0]                rem;
    logic [WB-1:0]              len_mask;
    logic [WB-1:0]              cand;
    logic                       hit;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Length clamped to the map size.
    assign len = (32'(bits_in_use_reg) > 32'(MAP_BITS)) ? 11'(MAP_BITS) : bits_in_use_reg;

    // Set search covers whole words only; clear search also the partial tail word.
    assign is_find_set = (cmd_reg == bscf_pkg::CMD_FIND_SET);
    assign limit       = is_find_set ? 7'(len >> 6) : 7'((12'(len) + 12'd63) >> 6);
    assign in_range    = 32'(cnt_reg) < 32'(limit);

    assign in_map    = 32'(idx_reg) < 32'(MAP_BITS);
    assign item_addr = AW'(idx_reg[9:6]);
    assign item_bit  = idx_reg[5:0];

    // Bits of the checked word that lie below the length.
    assign rem      = 32'(len) - (32'(chk_word_reg) << 6);
    assign len_mask = (rem >= 32'(WB)) ? {WB{1'b1}} : ((64'd1 << rem[5:0]) - 64'd1);
    assign cand     = is_find_set ? rd_data_reg : (~rd_data_reg & len_mask);
    assign hit      = chk_valid_reg && (cand != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bscf_pkg::ST_INIT:
            begin
                if (cnt_reg == CW'(NUM_WORDS - 1))
                    state_next = bscf_pkg::ST_IDLE;
            end
            bscf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser) inside
                        bscf_pkg::CMD_GET, bscf_pkg::CMD_SET, bscf_pkg::CMD_CLEAR:
                            state_next = bscf_pkg::ST_READ;
                        bscf_pkg::CMD_FIND_SET, bscf_pkg::CMD_FIND_CLEAR:
                            state_next = bscf_pkg::ST_SCAN;
                        default:
                            state_next = bscf_pkg::ST_EMIT;
                    endcase
                end
            end
            bscf_pkg::ST_READ:   state_next = bscf_pkg::ST_MODIFY;
            bscf_pkg::ST_MODIFY: state_next = bscf_pkg::ST_EMIT;
            bscf_pkg::ST_SCAN:
            begin
                if (hit)
                    state_next = bscf_pkg::ST_BITS;
                else if (!in_range && !chk_valid_reg)
                    state_next = bscf_pkg::ST_EMIT;   // all words checked, miss
            end
            bscf_pkg::ST_BITS:
            begin
                if (srch_resp.done)
                    state_next = bscf_pkg::ST_EMIT;
            end
            bscf_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = bscf_pkg::ST_IDLE;
            end
            default: state_next = bscf_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        s_tready        = 1'b0;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        chk_word_next   = chk_word_reg;
        chk_valid_next  = 1'b0;
        res_bit_next    = res_bit_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        rd_addr         = item_addr;
        wr_en           = 1'b0;
        wr_addr         = item_addr;
        wr_data         = rd_data_reg;
        srch_req.start    = 1'b0;
        srch_req.find_msb = is_find_set;
        srch_req.value    = cand;

        unique case (state_reg)
            bscf_pkg::ST_INIT:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[AW-1:0];
                wr_data  = '0;
                cnt_next = cnt_reg + CW'(1);
            end
            bscf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    cmd_next       = s_tuser;
                    idx_next       = s_tdata[9:0];
                    cnt_next       = '0;
                    res_bit_next   = 1'b0;
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                end
            end
            bscf_pkg::ST_READ:
            begin
                rd_addr = item_addr;
            end
            bscf_pkg::ST_MODIFY:
            begin
                unique case (cmd_reg)
                    bscf_pkg::CMD_GET:
                        res_bit_next = in_map && rd_data_reg[item_bit];
                    bscf_pkg::CMD_SET:
                    begin
                        wr_en   = in_map;
                        wr_data = rd_data_reg | (64'd1 << item_bit);
                    end
                    bscf_pkg::CMD_CLEAR:
                    begin
                        wr_en   = in_map;
                        wr_data = rd_data_reg & ~(64'd1 << item_bit);
                    end
                    default: ;
                endcase
            end
            bscf_pkg::ST_SCAN:
            begin
                // read word cnt while the word read last cycle is checked
                rd_addr = cnt_reg[AW-1:0];
                if (hit)
                    srch_req.start = 1'b1;
                else if (in_range)
                begin
                    chk_valid_next = 1'b1;
                    chk_word_next  = cnt_reg;
                    cnt_next       = cnt_reg + CW'(1);
                end
            end
            bscf_pkg::ST_BITS:
            begin
                if (srch_resp.done)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = 10'((32'(chk_word_reg) << 6) | 32'(srch_resp.index));
                end
            end
            bscf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, res_pos_reg, res_found_reg, res_bit_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bscf_pkg::ST_INIT;
            cnt_reg         <= '0;
            chk_valid_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            bits_in_use_reg <= bscf_pkg::LEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we)
                bits_in_use_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        chk_word_reg  <= chk_word_next;
        res_bit_reg   <= res_bit_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // word memory with one write port and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    bscf_bit_search u_bit_search (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (srch_req),
        .resp  (srch_resp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ hdl/bscf_checker.sv @@
// Port-level checker for the bitmap block, bound to the top level.
`default_nettype none
`include "bitmap_set_clear_find_top_defines.svh"

module bscf_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata
);

    `BSCF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
    `BSCF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second command taken while busy")
    `BSCF_ASSERT_SAME(a_get_or_search, m_tvalid, !(m_tdata[0] && m_tdata[1]), "bit_value and found both set")
    `BSCF_ASSERT_SAME(a_miss_zero, m_tvalid && !m_tdata[1], m_tdata[11:2] == 10'd0, "position not zero without a hit")

endmodule

bind bitmap_set_clear_find_top bscf_checker u_bscf_checker (.*);

`default_nettype wire
